// File: design/tepq_pkg.sv
// Shared types and constants for the timer expiry priority queue.
// Depends on nothing; the front end, the back end and the top level import it.
package tepq_pkg;

  // Fixed field widths of the transaction ports
  localparam int unsigned OP_W       = 2;
  localparam int unsigned FIELD_BITS = 48;
  localparam int unsigned HANDLER_W  = 8;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STATUS_W   = 2;

  // Defaults for the top-level parameters
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TIME_BITS_DEF   = 48;

  // At most this many expiry results per tick
  localparam int unsigned RESULT_CAP = 16;
  localparam int unsigned N_W        = $clog2(RESULT_CAP + 1);

  // Queue depths between front/back and at the result side
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned RESQ_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SET_AFTER = 2'd0,
    OP_SET_UNTIL = 2'd1,
    OP_TICK      = 2'd2
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET_STATUS = 2'd0,
    KIND_EXPIRED    = 2'd1,
    KIND_TICK_EMPTY = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_PAST     = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_PASS_END
  } back_state_e;

  typedef struct packed {
    op_e                   op;
    logic [FIELD_BITS-1:0] time_value;
    logic [HANDLER_W-1:0]  handler;
    logic [TAG_W-1:0]      tag;
  } cmd_t;

  typedef struct packed {
    kind_e                 kind;
    status_e               status;
    logic [HANDLER_W-1:0]  handler;
    logic [TAG_W-1:0]      tag;
    logic [FIELD_BITS-1:0] expiry;
    logic                  last;
  } result_t;

endpackage

// File: design/tepq_fifo.sv
// Small synchronous FIFO built from registers, one write and one read per cycle.
// Self-contained; used for the command queue and the result queue.
module tepq_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  output logic             rd_valid_o,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             rd_pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = data_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      data_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: design/tepq_front.sv
// Front end: accepts input transactions, decodes the operation, drops unused codes
// and queues commands for the back end. Depends on tepq_pkg and tepq_fifo.
module tepq_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [tepq_pkg::OP_W-1:0]           operation_i,
  input  logic [tepq_pkg::FIELD_BITS-1:0]     time_value_i,
  input  logic [tepq_pkg::HANDLER_W-1:0]      handler_id_i,
  input  logic [tepq_pkg::TAG_W-1:0]          timer_tag_i,
  output tepq_pkg::cmd_t                      cmd_o,
  output logic                                cmd_valid_o,
  input  logic                                cmd_pop_i
);
  import tepq_pkg::*;

  logic                 is_cmd;
  cmd_t                 cmd_in;
  logic [$bits(cmd_t)-1:0] q_data;

  // Operation code 3 is taken but has no effect, so it never enters the queue
  always_comb begin
    case (operation_i)
      OP_SET_AFTER, OP_SET_UNTIL, OP_TICK: is_cmd = 1'b1;
      default:                             is_cmd = 1'b0;
    endcase
  end

  assign cmd_in.op         = op_e'(operation_i);
  assign cmd_in.time_value = time_value_i;
  assign cmd_in.handler    = handler_id_i;
  assign cmd_in.tag        = timer_tag_i;

  tepq_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMDQ_DEPTH)
  ) u_cmdq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(push && is_cmd),
    .wr_data_i (cmd_in),
    .full_o    (full),
    .rd_valid_o(cmd_valid_o),
    .rd_data_o (q_data),
    .rd_pop_i  (cmd_pop_i)
  );

  assign cmd_o = cmd_t'(q_data);

endmodule

// File: design/tepq_back.sv
// Back end: timer slot storage, set handling and the expiry scan for ticks.
// Depends on tepq_pkg; results go to the result FIFO in the top level.
module tepq_back #(
  parameter int unsigned QUEUE_DEPTH = tepq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TIME_BITS   = tepq_pkg::TIME_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tepq_pkg::cmd_t    cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  output tepq_pkg::result_t res_o,
  output logic              res_push_o,
  input  logic              res_full_i
);
  import tepq_pkg::*;

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Slot storage (memory, registered read)
  logic [TIME_BITS-1:0] mem_time    [QUEUE_DEPTH];
  logic [HANDLER_W-1:0] mem_handler [QUEUE_DEPTH];
  logic [TAG_W-1:0]     mem_tag     [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] rd_time_q;
  logic [HANDLER_W-1:0] rd_hd_q;
  logic [TAG_W-1:0]     rd_tag_q;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;
  logic [TIME_BITS-1:0] mem_wtime;

  back_state_e          state_q, state_d;
  logic [QUEUE_DEPTH-1:0] valid_q, valid_d;
  logic [TIME_BITS-1:0] cur_q, cur_d;
  logic [TIME_BITS-1:0] near_q, near_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]     chk_idx_q, chk_idx_d;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic [TIME_BITS-1:0] best_time_q, best_time_d;
  logic [HANDLER_W-1:0] best_hd_q, best_hd_d;
  logic [TAG_W-1:0]     best_tag_q, best_tag_d;
  logic [TIME_BITS-1:0] min_q, min_d;
  logic [N_W-1:0]       n_q, n_d;
  logic                 pend_q, pend_d;
  result_t              pend_res_q, pend_res_d;

  logic [TIME_BITS-1:0] cmd_tv;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] armed_after;
  logic [TIME_BITS-1:0] armed;
  logic [IDX_W-1:0]     free_idx;
  logic                 free_any;

  assign cmd_tv      = TIME_BITS'(cmd_i.time_value);
  assign sum         = {1'b0, cur_q} + {1'b0, cmd_tv};
  assign armed_after = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign armed       = (cmd_i.op == OP_SET_AFTER) ? armed_after : cmd_tv;
  assign rd_addr     = cnt_q[IDX_W-1:0];
  assign mem_wtime   = armed;

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
        free_any = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    cur_d       = cur_q;
    near_d      = near_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_time_d = best_time_q;
    best_hd_d   = best_hd_q;
    best_tag_d  = best_tag_q;
    min_d       = min_q;
    n_d         = n_q;
    pend_d      = pend_q;
    pend_res_d  = pend_res_q;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    res_o       = '0;
    mem_we      = 1'b0;

    // Scan read issue, one slot per cycle
    rd_en     = (state_q == BK_SCAN) && (cnt_q < CNT_W'(QUEUE_DEPTH));
    chk_vld_d = rd_en;
    chk_idx_d = rd_addr;
    if (rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end

    // Compare the slot read last cycle; strict less-than keeps the lowest slot on ties
    if (chk_vld_q && valid_q[chk_idx_q]) begin
      if ((rd_time_q < cur_q) && (n_q < N_W'(RESULT_CAP)) &&
          (!found_q || (rd_time_q < best_time_q))) begin
        found_d     = 1'b1;
        best_idx_d  = chk_idx_q;
        best_time_d = rd_time_q;
        best_hd_d   = rd_hd_q;
        best_tag_d  = rd_tag_q;
      end
      if (rd_time_q < min_q) begin
        min_d = rd_time_q;
      end
    end

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_SET_AFTER, OP_SET_UNTIL: begin
              res_push_o = 1'b1;
              res_o.kind = KIND_SET_STATUS;
              res_o.expiry = FIELD_BITS'(armed);
              res_o.last = 1'b1;
              if ((cmd_i.op == OP_SET_UNTIL) && (cmd_tv < cur_q)) begin
                res_o.status = ST_PAST;
              end else if (!free_any) begin
                res_o.status = ST_FULL;
              end else begin
                res_o.status = ST_ACCEPTED;
                mem_we = 1'b1;
                valid_d[free_idx] = 1'b1;
                if (armed < near_q) begin
                  near_d = armed;
                end
              end
            end
            OP_TICK: begin
              cur_d = cmd_tv;
              if (cmd_tv <= near_q) begin
                // Nothing pending is earlier than the new time
                res_push_o  = 1'b1;
                res_o.kind  = KIND_TICK_EMPTY;
                res_o.last  = 1'b1;
              end else begin
                n_d     = '0;
                pend_d  = 1'b0;
                cnt_d   = '0;
                found_d = 1'b0;
                min_d   = '1;
                state_d = BK_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      BK_SCAN: begin
        if ((cnt_q == CNT_W'(QUEUE_DEPTH)) && !chk_vld_q) begin
          state_d = BK_PASS_END;
        end
      end

      BK_PASS_END: begin
        // The held expiry goes out once we know whether another follows
        if (!(pend_q || !found_q) || !res_full_i) begin
          if (pend_q) begin
            res_push_o = 1'b1;
            res_o      = pend_res_q;
            res_o.last = !found_q;
          end else if (!found_q) begin
            res_push_o = 1'b1;
            res_o.kind = KIND_TICK_EMPTY;
            res_o.last = 1'b1;
          end
          if (found_q) begin
            pend_d             = 1'b1;
            pend_res_d         = '0;
            pend_res_d.kind    = KIND_EXPIRED;
            pend_res_d.status  = ST_ACCEPTED;
            pend_res_d.handler = best_hd_q;
            pend_res_d.tag     = best_tag_q;
            pend_res_d.expiry  = FIELD_BITS'(best_time_q);
            valid_d[best_idx_q] = 1'b0;
            n_d     = n_q + 1'b1;
            cnt_d   = '0;
            found_d = 1'b0;
            min_d   = '1;
            state_d = BK_SCAN;
          end else begin
            near_d  = min_q;
            pend_d  = 1'b0;
            state_d = BK_IDLE;
          end
        end
      end

      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      valid_q   <= '0;
      cur_q     <= '0;
      near_q    <= '1;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      found_q   <= 1'b0;
      n_q       <= '0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      cur_q     <= cur_d;
      near_q    <= near_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= chk_vld_d;
      found_q   <= found_d;
      n_q       <= n_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q   <= chk_idx_d;
    best_idx_q  <= best_idx_d;
    best_time_q <= best_time_d;
    best_hd_q   <= best_hd_d;
    best_tag_q  <= best_tag_d;
    min_q       <= min_d;
    pend_res_q  <= pend_res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_time[free_idx]    <= mem_wtime;
      mem_handler[free_idx] <= cmd_i.handler;
      mem_tag[free_idx]     <= cmd_i.tag;
    end
    if (rd_en) begin
      rd_time_q <= mem_time[rd_addr];
      rd_hd_q   <= mem_handler[rd_addr];
      rd_tag_q  <= mem_tag[rd_addr];
    end
  end

endmodule

// File: design/timer_expiry_priority_queue_unit.sv
// Timer expiry priority queue, top level.
// Depends on tepq_pkg, tepq_fifo, tepq_front and tepq_back.
//
// Usage:
//  - Input side is a queue: a transaction is taken on a clock edge with push high
//    and full low. operation_i selects set-after (0), set-until (1) or tick (2);
//    code 3 is taken and ignored.
//  - Result side is a queue: while empty is low the oldest result sits on the
//    result ports; pop high on an edge takes it. last marks the final result of
//    one input transaction.
//  - A two-entry command queue sits between the front end and the back end, so
//    up to two transactions are taken back to back while the back end is busy.
//  - Set transactions: the back end takes one only while the result queue has
//    room, and writes its status into the result queue as it takes it.
//  - Tick: if the new time is not past the nearest pending expiry, the back end
//    writes an empty-tick result without a scan. Otherwise it scans the slot
//    memory one slot a cycle through its single read port, and a tick runs
//    (expired timers + 1) passes, at most RESULT_CAP + 1.
//  - When the receiver stalls, the back end holds in place once the two-entry
//    result queue is full; nothing is dropped.
//  - Reset clears all slots, the current time and the nearest expiry. There is
//    no clearing pass: the block is ready as soon as reset is released.
module timer_expiry_priority_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = tepq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TIME_BITS   = tepq_pkg::TIME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [tepq_pkg::OP_W-1:0]         operation_i,
  input  logic [tepq_pkg::FIELD_BITS-1:0]   time_value_i,
  input  logic [tepq_pkg::HANDLER_W-1:0]    handler_id_i,
  input  logic [tepq_pkg::TAG_W-1:0]        timer_tag_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [tepq_pkg::KIND_W-1:0]       result_kind_o,
  output logic [tepq_pkg::STATUS_W-1:0]     status_o,
  output logic [tepq_pkg::HANDLER_W-1:0]    expired_handler_o,
  output logic [tepq_pkg::TAG_W-1:0]        expired_tag_o,
  output logic [tepq_pkg::FIELD_BITS-1:0]   expiry_time_o,
  output logic                              last_o
);
  import tepq_pkg::*;

  cmd_t    cmd;
  logic    cmd_valid;
  logic    cmd_pop;
  result_t res_in;
  logic    res_push;
  logic    res_full;
  logic    res_valid;
  logic [$bits(result_t)-1:0] res_data;
  result_t res_out;

  tepq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .operation_i (operation_i),
    .time_value_i(time_value_i),
    .handler_id_i(handler_id_i),
    .timer_tag_i (timer_tag_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  tepq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .res_o      (res_in),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  // Result queue decouples the back end from a stalling receiver
  tepq_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(RESQ_DEPTH)
  ) u_resq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(res_push),
    .wr_data_i (res_in),
    .full_o    (res_full),
    .rd_valid_o(res_valid),
    .rd_data_o (res_data),
    .rd_pop_i  (pop)
  );

  assign res_out           = result_t'(res_data);
  assign empty             = !res_valid;
  assign result_kind_o     = res_out.kind;
  assign status_o          = res_out.status;
  assign expired_handler_o = res_out.handler;
  assign expired_tag_o     = res_out.tag;
  assign expiry_time_o     = res_out.expiry;
  assign last_o            = res_out.last;

  // Back end must never push into a full result queue
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push && res_full))
    else $error("result pushed into full result queue");

  // Back end only takes a command that is present
  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty command queue");

  // Status and empty-tick results always close their transaction
  a_single_results_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && (res_in.kind != KIND_EXPIRED)) |-> res_in.last)
    else $error("non-expiry result without last");

endmodule
